// ===== rtl/core/c8x_pkg.sv =====
package c8x_pkg;

    // fixed geometry of memory, screen and register file
    localparam int MEM_BYTES      = 4096;
    localparam int ADDR_W         = 12;
    localparam int SCREEN_WIDTH   = 64;
    localparam int SCREEN_HEIGHT  = 32;
    localparam int PIX_COUNT      = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int PIX_W          = 11;
    localparam int FONT_BYTES     = 80;
    localparam int STACK_DEPTH_DEF = 16;
    localparam logic [ADDR_W-1:0] PC_RESET = 12'd512;

    // command codes carried by an input transaction
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_EXEC   = 2'd1;
    localparam logic [1:0] CMD_RD_PIX = 2'd2;
    localparam logic [1:0] CMD_RD_MEM = 2'd3;

    // instruction groups (top nibble)
    localparam logic [3:0] K_SYS   = 4'h0;
    localparam logic [3:0] K_JP    = 4'h1;
    localparam logic [3:0] K_CALL  = 4'h2;
    localparam logic [3:0] K_SE    = 4'h3;
    localparam logic [3:0] K_SNE   = 4'h4;
    localparam logic [3:0] K_SER   = 4'h5;
    localparam logic [3:0] K_LDI8  = 4'h6;
    localparam logic [3:0] K_ADDI8 = 4'h7;
    localparam logic [3:0] K_ALU   = 4'h8;
    localparam logic [3:0] K_SNER  = 4'h9;
    localparam logic [3:0] K_LDI   = 4'hA;
    localparam logic [3:0] K_JPV0  = 4'hB;
    localparam logic [3:0] K_RND   = 4'hC;
    localparam logic [3:0] K_DRW   = 4'hD;
    localparam logic [3:0] K_KEY   = 4'hE;
    localparam logic [3:0] K_MISC  = 4'hF;

    localparam logic [15:0] OP_CLS = 16'h00E0;
    localparam logic [15:0] OP_RET = 16'h00EE;

    // alu sub-codes
    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    // key and misc sub-codes
    localparam logic [7:0] KEY_SKP  = 8'h9E;
    localparam logic [7:0] KEY_SKNP = 8'hA1;
    localparam logic [7:0] MX_GDT   = 8'h07;
    localparam logic [7:0] MX_KEY   = 8'h0A;
    localparam logic [7:0] MX_SDT   = 8'h15;
    localparam logic [7:0] MX_SST   = 8'h18;
    localparam logic [7:0] MX_ADDI  = 8'h1E;
    localparam logic [7:0] MX_FONT  = 8'h29;
    localparam logic [7:0] MX_BCD   = 8'h33;
    localparam logic [7:0] MX_STR   = 8'h55;
    localparam logic [7:0] MX_LDR   = 8'h65;

    localparam logic [3:0] REG_VF = 4'hF;

    // hex glyphs held in the low memory bytes after reset
    localparam logic [7:0] FONT [FONT_BYTES] = '{
        8'hf0, 8'h90, 8'h90, 8'h90, 8'hf0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hf0, 8'h10, 8'hf0, 8'h80, 8'hf0, 8'hf0, 8'h10, 8'hf0, 8'h10, 8'hf0,
        8'h90, 8'h90, 8'hf0, 8'h10, 8'h10, 8'hf0, 8'h80, 8'hf0, 8'h10, 8'hf0,
        8'hf0, 8'h80, 8'hf0, 8'h90, 8'hf0, 8'hf0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hf0, 8'h90, 8'hf0, 8'h90, 8'hf0, 8'hf0, 8'h90, 8'hf0, 8'h10, 8'hf0,
        8'hf0, 8'h90, 8'hf0, 8'h90, 8'h90, 8'he0, 8'h90, 8'he0, 8'h90, 8'he0,
        8'hf0, 8'h80, 8'h80, 8'h80, 8'hf0, 8'he0, 8'h90, 8'h90, 8'h90, 8'he0,
        8'hf0, 8'h80, 8'hf0, 8'h80, 8'hf0, 8'hf0, 8'h80, 8'hf0, 8'h80, 8'h80
    };

    // micro-operations issued by the controller each cycle
    typedef enum logic [4:0] {
        UOP_NOP,
        UOP_CLEAR,
        UOP_ACCEPT,
        UOP_LOAD,
        UOP_RD_ISSUE,
        UOP_RD_CAP,
        UOP_FETCH_HI,
        UOP_FETCH_LO,
        UOP_FETCH_OP,
        UOP_RD_VY,
        UOP_CAP_VY,
        UOP_EXEC,
        UOP_CLS,
        UOP_RET_WR,
        UOP_WR_Y,
        UOP_WR_X,
        UOP_BCD1,
        UOP_BCD2,
        UOP_ST_RD,
        UOP_ST_WR,
        UOP_LD_RD,
        UOP_LD_WR,
        UOP_SPR_MEM,
        UOP_SPR_LINE,
        UOP_SPR_PRD,
        UOP_SPR_PWR,
        UOP_SPR_VF,
        UOP_FINISH
    } uop_t;

    // status returned by the datapath
    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] op;
        logic        clear_last;
        logic        cls_last;
        logic        cnt_eq_x;
        logic        bit_last;
        logic        row_last;
    } ctl_status_t;

endpackage

// ===== rtl/core/c8x_ctrl.sv =====
module c8x_ctrl
    import c8x_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  ctl_status_t status,
    output uop_t        uop
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_RD_CAP, S_F2, S_F3, S_F4, S_F5, S_EXEC,
        S_CLS, S_RET, S_WR_Y, S_WR_X, S_BCD1, S_BCD2, S_ST_RD, S_ST_WR,
        S_LD_RD, S_LD_WR, S_SPR_MEM, S_SPR_LINE, S_SPR_PRD, S_SPR_PWR,
        S_SPR_VF, S_FINISH
    } state_t;

    state_t     state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic [3:0] kind;
    logic [3:0] sub;
    logic [7:0] lo;

    assign kind = status.op[15:12];
    assign sub  = status.op[3:0];
    assign lo   = status.op[7:0];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;

    // sequencing of micro-operations
    always_comb
    begin
        state_next = state_reg;
        uop        = UOP_NOP;
        unique case (state_reg)
            S_CLEAR:
            begin
                uop = UOP_CLEAR;
                if (status.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    uop        = UOP_ACCEPT;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (status.cmd)
                    CMD_LOAD:
                    begin
                        uop        = UOP_LOAD;
                        state_next = S_FINISH;
                    end
                    CMD_EXEC:
                    begin
                        uop        = UOP_FETCH_HI;
                        state_next = S_F2;
                    end
                    default:
                    begin
                        uop        = UOP_RD_ISSUE;
                        state_next = S_RD_CAP;
                    end
                endcase
            end
            S_RD_CAP:
            begin
                uop        = UOP_RD_CAP;
                state_next = S_FINISH;
            end
            S_F2:
            begin
                uop        = UOP_FETCH_LO;
                state_next = S_F3;
            end
            S_F3:
            begin
                uop        = UOP_FETCH_OP;
                state_next = S_F4;
            end
            S_F4:
            begin
                uop        = UOP_RD_VY;
                state_next = S_F5;
            end
            S_F5:
            begin
                uop        = UOP_CAP_VY;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                uop = UOP_EXEC;
                priority if (status.op == OP_CLS)
                    state_next = S_CLS;
                else if (status.op == OP_RET)
                    state_next = S_RET;
                else if (kind == K_ALU && (sub == ALU_ADD || sub == ALU_SUB
                                           || sub == ALU_SBN))
                    state_next = S_WR_X;
                else if (kind == K_ALU && (sub == ALU_SHR || sub == ALU_SHL))
                    state_next = S_WR_Y;
                else if (kind == K_DRW && sub != 4'd0)
                    state_next = S_SPR_MEM;
                else if (kind == K_MISC && lo == MX_BCD)
                    state_next = S_BCD1;
                else if (kind == K_MISC && lo == MX_STR)
                    state_next = S_ST_RD;
                else if (kind == K_MISC && lo == MX_LDR)
                    state_next = S_LD_RD;
                else
                    state_next = S_FINISH;
            end
            S_CLS:
            begin
                uop = UOP_CLS;
                if (status.cls_last)
                    state_next = S_FINISH;
            end
            S_RET:
            begin
                uop        = UOP_RET_WR;
                state_next = S_FINISH;
            end
            S_WR_Y:
            begin
                uop        = UOP_WR_Y;
                state_next = S_WR_X;
            end
            S_WR_X:
            begin
                uop        = UOP_WR_X;
                state_next = S_FINISH;
            end
            S_BCD1:
            begin
                uop        = UOP_BCD1;
                state_next = S_BCD2;
            end
            S_BCD2:
            begin
                uop        = UOP_BCD2;
                state_next = S_FINISH;
            end
            S_ST_RD:
            begin
                uop        = UOP_ST_RD;
                state_next = S_ST_WR;
            end
            S_ST_WR:
            begin
                uop        = UOP_ST_WR;
                state_next = status.cnt_eq_x ? S_FINISH : S_ST_RD;
            end
            S_LD_RD:
            begin
                uop        = UOP_LD_RD;
                state_next = S_LD_WR;
            end
            S_LD_WR:
            begin
                uop        = UOP_LD_WR;
                state_next = status.cnt_eq_x ? S_FINISH : S_LD_RD;
            end
            S_SPR_MEM:
            begin
                uop        = UOP_SPR_MEM;
                state_next = S_SPR_LINE;
            end
            S_SPR_LINE:
            begin
                uop        = UOP_SPR_LINE;
                state_next = S_SPR_PRD;
            end
            S_SPR_PRD:
            begin
                uop        = UOP_SPR_PRD;
                state_next = S_SPR_PWR;
            end
            S_SPR_PWR:
            begin
                uop = UOP_SPR_PWR;
                priority if (!status.bit_last)
                    state_next = S_SPR_PRD;
                else if (status.row_last)
                    state_next = S_SPR_VF;
                else
                    state_next = S_SPR_MEM;
            end
            S_SPR_VF:
            begin
                uop        = UOP_SPR_VF;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // wait for the output register to be free
                if (!m_valid_reg || m_axis_tready)
                begin
                    uop        = UOP_FINISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (uop == UOP_FINISH)
            m_valid_next = 1'b1;
        else if (m_axis_tready)
            m_valid_next = 1'b0;
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== rtl/core/c8x_datapath.sv =====
module c8x_datapath
    import c8x_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  uop_t        uop,
    input  logic [39:0] s_axis_tdata,
    output logic [23:0] m_axis_tdata,
    output ctl_status_t status
);

    localparam int SP_W = $clog2(STACK_DEPTH);

    // storage
    logic [7:0]        mem [MEM_BYTES];
    logic [7:0]        rf [16];
    logic [ADDR_W-1:0] stack_mem [STACK_DEPTH];
    logic              scr [PIX_COUNT];

    logic [7:0]        mem_q;
    logic [7:0]        rf_q;
    logic [ADDR_W-1:0] stk_q;
    logic              scr_q;

    // architectural and sequencing registers
    logic [ADDR_W-1:0] pc_reg, pc_next;
    logic [15:0]       i_reg, i_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [7:0]        dt_reg, dt_next;
    logic [7:0]        st_reg, st_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [2:0]        bit_reg, bit_next;
    logic              hit_reg, hit_next;

    // transaction and working registers
    logic [1:0]        icmd_reg;
    logic [ADDR_W-1:0] iaddr_reg;
    logic [7:0]        idata_reg, ikey_reg, irnd_reg;
    logic [15:0]       op_reg;
    logic [7:0]        vx_reg, vy_reg, line_reg, rv_reg;
    logic              flag_reg, unk_reg, drew_reg;
    logic [PIX_W-1:0]  pos_reg;
    logic [ADDR_W-1:0] out_pc_reg;
    logic [7:0]        out_rv_reg;
    logic              out_unk_reg, out_drew_reg;

    // port controls
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [7:0]        mem_wdata;
    logic              rf_we;
    logic [3:0]        rf_waddr, rf_raddr;
    logic [7:0]        rf_wdata;
    logic              stk_we;
    logic              scr_we;
    logic [PIX_W-1:0]  scr_waddr, scr_raddr;
    logic              scr_wdata;

    // decoded fields
    logic [3:0]        kind, x, y, n;
    logic [7:0]        lo;
    logic [ADDR_W-1:0] nnn;

    assign kind = op_reg[15:12];
    assign x    = op_reg[11:8];
    assign y    = op_reg[7:4];
    assign n    = op_reg[3:0];
    assign lo   = op_reg[7:0];
    assign nnn  = op_reg[11:0];

    // derived values
    logic [ADDR_W-1:0] pc_step, pc_skip;
    logic [SP_W-1:0]   sp_inc, sp_dec;
    logic [8:0]        sum9;
    logic              alu_flag;
    logic [7:0]        vxp, vyp, alu2;
    logic [7:0]        key_val;
    logic [1:0]        hund;
    logic [7:0]        rem;
    logic [14:0]       tens_prod;
    logic [3:0]        tens;
    logic [7:0]        ones;
    logic [8:0]        row_y;
    logic [14:0]       pos_full;
    logic [14:0]       pos_wrap;
    logic [PIX_W-1:0]  pos_inc;
    logic              spr_bit;
    logic              take_skip;

    assign pc_step = pc_reg + 12'd2;
    assign pc_skip = pc_reg + 12'd4;
    assign sp_inc  = (sp_reg == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_reg + 1'b1;
    assign sp_dec  = (sp_reg == '0) ? SP_W'(STACK_DEPTH - 1) : sp_reg - 1'b1;

    // raw character to hex key
    always_comb
    begin
        priority if (ikey_reg >= 8'h30 && ikey_reg <= 8'h39)
            key_val = ikey_reg - 8'h30;
        else if (ikey_reg >= 8'h61 && ikey_reg <= 8'h66)
            key_val = ikey_reg - 8'h57;
        else if (ikey_reg >= 8'h41 && ikey_reg <= 8'h46)
            key_val = ikey_reg - 8'h37;
        else
            key_val = 8'hFF;
    end

    // flag for the alu group, from registers before any write
    assign sum9 = {1'b0, vx_reg} + {1'b0, vy_reg};
    always_comb
    begin
        unique case (n)
            ALU_ADD: alu_flag = sum9[8];
            ALU_SUB: alu_flag = (vx_reg >= vy_reg);
            ALU_SHR: alu_flag = vy_reg[0];
            ALU_SBN: alu_flag = (vy_reg >= vx_reg);
            ALU_SHL: alu_flag = vy_reg[7];
            default: alu_flag = 1'b0;
        endcase
    end

    // second alu result, from registers as they stand after the flag write
    assign vxp = (x == REG_VF) ? {7'd0, flag_reg} : vx_reg;
    assign vyp = (y == REG_VF) ? {7'd0, flag_reg} : vy_reg;
    always_comb
    begin
        unique case (n)
            ALU_ADD: alu2 = vxp + vyp;
            ALU_SUB: alu2 = vxp - vyp;
            ALU_SBN: alu2 = vyp - vxp;
            ALU_SHR: alu2 = {1'b0, vyp[7:1]};
            ALU_SHL: alu2 = {vyp[6:0], 1'b0};
            default: alu2 = vxp;
        endcase
    end

    // decimal digits of vx
    always_comb
    begin
        priority if (vx_reg >= 8'd200)
            hund = 2'd2;
        else if (vx_reg >= 8'd100)
            hund = 2'd1;
        else
            hund = 2'd0;
    end
    assign rem       = vx_reg - ((hund == 2'd2) ? 8'd200 : (hund == 2'd1) ? 8'd100 : 8'd0);
    assign tens_prod = {7'd0, rem} * 15'd205;
    assign tens      = tens_prod[14:11];
    assign ones      = rem - ({4'd0, tens} * 8'd10);

    // sprite pixel position with bottom wrap
    assign row_y    = {1'b0, vy_reg} + {5'd0, cnt_reg[3:0]};
    assign pos_full = {row_y, 6'd0} + {7'd0, vx_reg};
    assign pos_wrap = (pos_full > 15'(PIX_COUNT - 1)) ? pos_full - 15'd64 : pos_full;
    assign pos_inc  = (pos_reg == PIX_W'(PIX_COUNT - 1)) ? PIX_W'(PIX_COUNT - SCREEN_WIDTH)
                                                         : pos_reg + 1'b1;
    assign spr_bit  = line_reg[3'd7 - bit_reg];

    // skip decisions
    always_comb
    begin
        unique case (kind)
            K_SE:    take_skip = (vx_reg == lo);
            K_SNE:   take_skip = (vx_reg != lo);
            K_SER:   take_skip = (vx_reg == vy_reg);
            K_SNER:  take_skip = (vx_reg != vy_reg);
            K_KEY:   take_skip = (lo == KEY_SKP) ? (key_val == vx_reg)
                               : (lo == KEY_SKNP) ? (key_val != vx_reg) : 1'b0;
            default: take_skip = 1'b0;
        endcase
    end

    // status to the controller
    assign status.cmd        = icmd_reg;
    assign status.op         = op_reg;
    assign status.clear_last = (cnt_reg == ADDR_W'(MEM_BYTES - 1));
    assign status.cls_last   = (cnt_reg[PIX_W-1:0] == PIX_W'(PIX_COUNT - 1));
    assign status.cnt_eq_x   = (cnt_reg[3:0] == x);
    assign status.bit_last   = (bit_reg == 3'd7);
    assign status.row_last   = ({1'b0, cnt_reg[3:0]} + 5'd1 == {1'b0, n});

    assign m_axis_tdata = {2'b00, out_rv_reg, out_drew_reg, out_unk_reg, out_pc_reg};

    // memory ports and architectural updates
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = i_reg[ADDR_W-1:0];
        mem_wdata = 8'd0;
        mem_raddr = pc_reg;
        rf_we     = 1'b0;
        rf_waddr  = x;
        rf_wdata  = 8'd0;
        rf_raddr  = x;
        stk_we    = 1'b0;
        scr_we    = 1'b0;
        scr_waddr = pos_reg;
        scr_wdata = 1'b0;
        scr_raddr = pos_reg;
        pc_next   = pc_reg;
        i_next    = i_reg;
        sp_next   = sp_reg;
        dt_next   = dt_reg;
        st_next   = st_reg;
        cnt_next  = cnt_reg;
        bit_next  = bit_reg;
        hit_next  = hit_reg;
        unique case (uop)
            UOP_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = (cnt_reg < ADDR_W'(FONT_BYTES)) ? FONT[cnt_reg[6:0]] : 8'd0;
                rf_we     = 1'b1;
                rf_waddr  = cnt_reg[3:0];
                scr_we    = 1'b1;
                scr_waddr = cnt_reg[PIX_W-1:0];
                cnt_next  = cnt_reg + 1'b1;
            end
            UOP_LOAD:
            begin
                mem_we    = 1'b1;
                mem_waddr = iaddr_reg;
                mem_wdata = idata_reg;
            end
            UOP_RD_ISSUE:
            begin
                mem_raddr = iaddr_reg;
                scr_raddr = iaddr_reg[PIX_W-1:0];
            end
            UOP_FETCH_LO:
            begin
                mem_raddr = pc_reg + 1'b1;
            end
            UOP_FETCH_OP:
            begin
                rf_raddr = (kind == K_JPV0) ? 4'd0 : x;
            end
            UOP_RD_VY:
            begin
                rf_raddr = y;
            end
            UOP_EXEC:
            begin
                cnt_next = '0;
                bit_next = '0;
                hit_next = 1'b0;
                pc_next  = take_skip ? pc_skip : pc_step;
                unique case (kind)
                    K_SYS:
                    begin
                        if (op_reg == OP_RET)
                            sp_next = sp_dec;
                    end
                    K_JP:
                        pc_next = nnn;
                    K_CALL:
                    begin
                        stk_we  = 1'b1;
                        sp_next = sp_inc;
                        pc_next = nnn;
                    end
                    K_LDI8:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = lo;
                    end
                    K_ADDI8:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = vx_reg + lo;
                    end
                    K_ALU:
                    begin
                        unique case (n)
                            ALU_MOV:
                            begin
                                rf_we    = 1'b1;
                                rf_wdata = vy_reg;
                            end
                            ALU_OR:
                            begin
                                rf_we    = 1'b1;
                                rf_wdata = vx_reg | vy_reg;
                            end
                            ALU_AND:
                            begin
                                rf_we    = 1'b1;
                                rf_wdata = vx_reg & vy_reg;
                            end
                            ALU_XOR:
                            begin
                                rf_we    = 1'b1;
                                rf_wdata = vx_reg ^ vy_reg;
                            end
                            ALU_ADD, ALU_SUB, ALU_SHR, ALU_SBN, ALU_SHL:
                            begin
                                rf_we    = 1'b1;
                                rf_waddr = REG_VF;
                                rf_wdata = {7'd0, alu_flag};
                            end
                            default:
                            begin
                                rf_we = 1'b0;
                            end
                        endcase
                    end
                    K_LDI:
                        i_next = {4'd0, nnn};
                    K_JPV0:
                        pc_next = nnn + {4'd0, vx_reg};
                    K_RND:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = irnd_reg & lo;
                    end
                    K_MISC:
                    begin
                        unique case (lo)
                            MX_GDT:
                            begin
                                rf_we    = 1'b1;
                                rf_wdata = dt_reg;
                            end
                            MX_KEY:
                            begin
                                rf_we    = 1'b1;
                                rf_wdata = key_val;
                            end
                            MX_SDT:  dt_next = vx_reg;
                            MX_SST:  st_next = vx_reg;
                            MX_ADDI: i_next  = i_reg + {8'd0, vx_reg};
                            MX_FONT: i_next  = {6'd0, vx_reg, 2'd0} + {8'd0, vx_reg};
                            MX_BCD:
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = {6'd0, hund};
                            end
                            default:
                            begin
                                mem_we = 1'b0;
                            end
                        endcase
                    end
                    default:
                    begin
                        stk_we = 1'b0;
                    end
                endcase
            end
            UOP_CLS:
            begin
                scr_we    = 1'b1;
                scr_waddr = cnt_reg[PIX_W-1:0];
                cnt_next  = cnt_reg + 1'b1;
            end
            UOP_RET_WR:
                pc_next = stk_q;
            UOP_WR_Y:
            begin
                rf_we    = 1'b1;
                rf_waddr = y;
                rf_wdata = alu2;
            end
            UOP_WR_X:
            begin
                rf_we    = 1'b1;
                rf_wdata = alu2;
            end
            UOP_BCD1:
            begin
                mem_we    = 1'b1;
                mem_waddr = i_reg[ADDR_W-1:0] + 12'd1;
                mem_wdata = {4'd0, tens};
            end
            UOP_BCD2:
            begin
                mem_we    = 1'b1;
                mem_waddr = i_reg[ADDR_W-1:0] + 12'd2;
                mem_wdata = {4'd0, ones[3:0]};
            end
            UOP_ST_RD:
                rf_raddr = cnt_reg[3:0];
            UOP_ST_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = rf_q;
                i_next    = i_reg + 16'd1;
                cnt_next  = cnt_reg + 1'b1;
            end
            UOP_LD_RD:
                mem_raddr = i_reg[ADDR_W-1:0];
            UOP_LD_WR:
            begin
                rf_we    = 1'b1;
                rf_waddr = cnt_reg[3:0];
                rf_wdata = mem_q;
                i_next   = i_reg + 16'd1;
                cnt_next = cnt_reg + 1'b1;
            end
            UOP_SPR_MEM:
                mem_raddr = i_reg[ADDR_W-1:0] + {8'd0, cnt_reg[3:0]};
            UOP_SPR_LINE:
                bit_next = '0;
            UOP_SPR_PWR:
            begin
                scr_we    = 1'b1;
                scr_wdata = scr_q ^ spr_bit;
                hit_next  = hit_reg | (scr_q & spr_bit);
                bit_next  = bit_reg + 1'b1;
                if (bit_reg == 3'd7)
                    cnt_next = cnt_reg + 1'b1;
            end
            UOP_SPR_VF:
            begin
                rf_we    = 1'b1;
                rf_waddr = REG_VF;
                rf_wdata = {7'd0, hit_reg};
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // memories with registered read data
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_q <= mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rf_we)
            rf[rf_waddr] <= rf_wdata;
        rf_q <= rf[rf_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stack_mem[sp_reg] <= pc_step;
        stk_q <= stack_mem[sp_dec];
    end

    always_ff @(posedge clk)
    begin
        if (scr_we)
            scr[scr_waddr] <= scr_wdata;
        scr_q <= scr[scr_raddr];
    end

    // architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= PC_RESET;
            i_reg   <= '0;
            sp_reg  <= '0;
            dt_reg  <= '0;
            st_reg  <= '0;
            cnt_reg <= '0;
            bit_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            pc_reg  <= pc_next;
            i_reg   <= i_next;
            sp_reg  <= sp_next;
            dt_reg  <= dt_next;
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
            bit_reg <= bit_next;
            hit_reg <= hit_next;
        end
    end

    // transaction and working registers
    always_ff @(posedge clk)
    begin
        unique case (uop)
            UOP_ACCEPT:
            begin
                icmd_reg  <= s_axis_tdata[1:0];
                iaddr_reg <= s_axis_tdata[13:2];
                idata_reg <= s_axis_tdata[21:14];
                ikey_reg  <= s_axis_tdata[29:22];
                irnd_reg  <= s_axis_tdata[37:30];
                unk_reg   <= 1'b0;
                drew_reg  <= 1'b0;
                rv_reg    <= 8'd0;
            end
            UOP_RD_CAP:
                rv_reg <= (icmd_reg == CMD_RD_PIX) ? {7'd0, scr_q} : mem_q;
            UOP_FETCH_LO:
                op_reg[15:8] <= mem_q;
            UOP_FETCH_OP:
                op_reg[7:0] <= mem_q;
            UOP_RD_VY:
                vx_reg <= rf_q;
            UOP_CAP_VY:
                vy_reg <= rf_q;
            UOP_EXEC:
            begin
                flag_reg <= alu_flag;
                drew_reg <= (kind == K_DRW);
                unique case (kind)
                    K_SYS:
                        unk_reg <= (op_reg != OP_CLS) && (op_reg != OP_RET);
                    K_ALU:
                        unk_reg <= !(n <= ALU_SBN || n == ALU_SHL);
                    K_KEY:
                        unk_reg <= (lo != KEY_SKP) && (lo != KEY_SKNP);
                    K_MISC:
                        unk_reg <= !(lo == MX_GDT || lo == MX_KEY || lo == MX_SDT
                                     || lo == MX_SST || lo == MX_ADDI || lo == MX_FONT
                                     || lo == MX_BCD || lo == MX_STR || lo == MX_LDR);
                    default:
                        unk_reg <= 1'b0;
                endcase
            end
            UOP_SPR_LINE:
            begin
                line_reg <= mem_q;
                pos_reg  <= pos_wrap[PIX_W-1:0];
            end
            UOP_SPR_PWR:
                pos_reg <= pos_inc;
            UOP_FINISH:
            begin
                out_pc_reg   <= pc_reg;
                out_unk_reg  <= unk_reg;
                out_drew_reg <= drew_reg;
                out_rv_reg   <= rv_reg;
            end
            default:
            begin
                flag_reg <= flag_reg;
            end
        endcase
    end

endmodule

// ===== rtl/core/chip8_instruction_executor.sv =====
// channel | dir | signals                       | payload
// s_axis  | in  | tvalid tready tdata[39:0]     | command transaction
// m_axis  | out | tvalid tready tdata[23:0]     | result transaction, one per command
//
// after reset a clearing pass loads the glyphs, zeroes memory, registers and
// screen; s_axis_tready stays low until it ends. a result waits in the output
// register. a load is accepted and written, a read issued and captured, and an
// instruction fetches both bytes and reads vx and vy, then executes, all bound by
// the single port of the main memory and register file; 00E0 then clears pixels,
// DXYN draws rows, FX55/65 copy registers, 00EE pops pc, 8XY4-7/E, FX33 write back.
module chip8_instruction_executor
    import c8x_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd[1:0] address[13:2] data[21:14] key_char[29:22] random_byte[37:30]
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pc_out[11:0] unknown_opcode[12] display_changed[13] read_value[21:14]
    output logic [23:0] m_axis_tdata
);

    uop_t        uop;
    ctl_status_t status;

    // sequencer
    c8x_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .status        (status),
        .uop           (uop)
    );

    // storage and execution
    c8x_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .uop          (uop),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tdata (m_axis_tdata),
        .status       (status)
    );

endmodule

// ===== rtl/core/c8x_checker.sv =====
module c8x_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata
);

    // a held result stays valid
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a held result keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one command in flight at a time
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second command taken while busy");

    // a draw is always a known instruction
    a_draw_known: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[12] && m_axis_tdata[13]))
        else $error("draw flagged as unknown");

endmodule

bind chip8_instruction_executor c8x_checker u_c8x_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== dv/chip8_instruction_executor_checker.sv =====
module chip8_instruction_executor_checker
    import c8x_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    output int          err_count,
    output int          pending,
    output logic [11:0] model_pc
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]  rd_val;
        logic        drew;
        logic        unk;
        logic [11:0] pc;
    } outcome_t;

    // shadow copy of the core state
    logic [7:0]  mem [MEM_BYTES];
    logic [7:0]  v [16];
    logic [11:0] stk [STACK_DEPTH_DEF];
    int          sp;
    logic [11:0] pc;
    logic [15:0] ireg;
    logic [7:0]  dly;
    logic [7:0]  snd;
    logic        scr [PIX_COUNT];
    outcome_t    outcome_q [$];
    int          errs;

    function automatic logic [7:0] key_code(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 8'd10;
        if (c >= "A" && c <= "F") return c - "A" + 8'd10;
        return 8'hFF;
    endfunction

    // xor a sprite onto the screen, vf flags a collision anywhere in the sprite
    task automatic draw_sprite(input logic [7:0] px, input logic [7:0] py, input int rows);
        bit hit;
        int pos;
        logic [7:0] line;
        hit = 0;
        for (int r = 0; r < rows; r++)
        begin
            pos = px + 64 * (py + r);
            line = mem[12'(ireg + r)];
            for (int b = 0; b < 8; b++)
            begin
                if (pos > PIX_COUNT - 1) pos -= 64;
                pos &= PIX_COUNT - 1;
                if (scr[pos] && line[7-b])
                begin
                    v[REG_VF] = 8'd1;
                    hit = 1;
                end
                scr[pos] ^= line[7-b];
                pos++;
            end
            if (!hit) v[REG_VF] = 8'd0;
        end
    endtask

    // one instruction at the shadow pc
    task automatic run_instr(input logic [7:0] kc, input logic [7:0] rb, output outcome_t o);
        logic [15:0] op;
        logic [3:0]  kind, x, y, n;
        logic [7:0]  lo;
        logic [11:0] nxt;
        logic [8:0]  sum;
        o = '0;
        op = {mem[pc], mem[12'(pc + 1)]};
        kind = op[15:12];
        x = op[11:8];
        y = op[7:4];
        n = op[3:0];
        lo = op[7:0];
        nxt = pc + 12'd2;
        case (kind)
            K_SYS:
                if (op == OP_CLS)
                begin
                    for (int i = 0; i < PIX_COUNT; i++) scr[i] = 0;
                end
                else if (op == OP_RET)
                begin
                    sp = (sp == 0) ? STACK_DEPTH_DEF - 1 : sp - 1;
                    nxt = stk[sp];
                end
                else o.unk = 1;
            K_JP: nxt = op[11:0];
            K_CALL:
            begin
                stk[sp] = nxt;
                sp = (sp + 1 >= STACK_DEPTH_DEF) ? 0 : sp + 1;
                nxt = op[11:0];
            end
            K_SE:   if (v[x] == lo) nxt += 12'd2;
            K_SNE:  if (v[x] != lo) nxt += 12'd2;
            K_SER:  if (v[x] == v[y]) nxt += 12'd2;
            K_SNER: if (v[x] != v[y]) nxt += 12'd2;
            K_LDI8:  v[x] = lo;
            K_ADDI8: v[x] = v[x] + lo;
            K_ALU:
                case (n)
                    ALU_MOV: v[x] = v[y];
                    ALU_OR:  v[x] = v[x] | v[y];
                    ALU_AND: v[x] = v[x] & v[y];
                    ALU_XOR: v[x] = v[x] ^ v[y];
                    ALU_ADD:
                    begin
                        sum = v[x] + v[y];
                        v[REG_VF] = {7'd0, sum[8]};
                        v[x] = v[x] + v[y];
                    end
                    ALU_SUB:
                    begin
                        v[REG_VF] = (v[x] >= v[y]) ? 8'd1 : 8'd0;
                        v[x] = v[x] - v[y];
                    end
                    ALU_SHR:
                    begin
                        v[REG_VF] = {7'd0, v[y][0]};
                        v[y] = v[y] >> 1;
                        v[x] = v[y];
                    end
                    ALU_SBN:
                    begin
                        v[REG_VF] = (v[y] >= v[x]) ? 8'd1 : 8'd0;
                        v[x] = v[y] - v[x];
                    end
                    ALU_SHL:
                    begin
                        v[REG_VF] = {7'd0, v[y][7]};
                        v[y] = v[y] << 1;
                        v[x] = v[y];
                    end
                    default: o.unk = 1;
                endcase
            K_LDI:  ireg = {4'd0, op[11:0]};
            K_JPV0: nxt = 12'(v[0] + op[11:0]);
            K_RND:  v[x] = rb & lo;
            K_DRW:
            begin
                draw_sprite(v[x], v[y], n);
                o.drew = 1;
            end
            K_KEY:
                if (lo == KEY_SKP)
                begin
                    if (key_code(kc) == v[x]) nxt += 12'd2;
                end
                else if (lo == KEY_SKNP)
                begin
                    if (key_code(kc) != v[x]) nxt += 12'd2;
                end
                else o.unk = 1;
            default:
                case (lo)
                    MX_GDT:  v[x] = dly;
                    MX_SDT:  dly = v[x];
                    MX_SST:  snd = v[x];
                    MX_FONT: ireg = v[x] * 16'd5;
                    MX_ADDI: ireg = ireg + v[x];
                    MX_STR:
                        for (int i = 0; i <= x; i++)
                        begin
                            mem[ireg[11:0]] = v[i];
                            ireg++;
                        end
                    MX_LDR:
                        for (int i = 0; i <= x; i++)
                        begin
                            v[i] = mem[ireg[11:0]];
                            ireg++;
                        end
                    MX_KEY: v[x] = key_code(kc);
                    MX_BCD:
                    begin
                        mem[ireg[11:0]] = v[x] / 8'd100;
                        mem[12'(ireg + 1)] = (v[x] / 8'd10) % 8'd10;
                        mem[12'(ireg + 2)] = v[x] % 8'd10;
                    end
                    default: o.unk = 1;
                endcase
        endcase
        pc = nxt;
    endtask

    // expected result of one command transaction
    task automatic predict(input logic [39:0] t, output outcome_t o);
        o = '0;
        case (t[1:0])
            CMD_LOAD:   mem[t[13:2]] = t[21:14];
            CMD_EXEC:   run_instr(t[29:22], t[37:30], o);
            CMD_RD_PIX: o.rd_val = {7'd0, scr[t[12:2]]};
            default:    o.rd_val = mem[t[13:2]];
        endcase
        o.pc = pc;
    endtask

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errs++;
    endtask

    // watch both channels
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t o, g;
        if (!rst_n)
        begin
            for (int i = 0; i < MEM_BYTES; i++) mem[i] = (i < FONT_BYTES) ? FONT[i] : 8'd0;
            for (int i = 0; i < 16; i++) v[i] = 8'd0;
            for (int i = 0; i < PIX_COUNT; i++) scr[i] = 0;
            sp = 0;
            pc = PC_RESET;
            ireg = '0;
            dly = '0;
            snd = '0;
            outcome_q.delete();
            errs = 0;
            err_count <= 0;
            pending <= 0;
            model_pc <= PC_RESET;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict(s_axis_tdata, o);
                outcome_q.push_back(o);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                g = m_axis_tdata[21:0];
                if (outcome_q.size() == 0)
                begin
                    report("unexpected result", m_axis_tdata, 0);
                end
                else
                begin
                    o = outcome_q.pop_front();
                    if (g.pc != o.pc) report("pc_out", g.pc, o.pc);
                    if (g.unk != o.unk) report("unknown_opcode", g.unk, o.unk);
                    if (g.drew != o.drew) report("display_changed", g.drew, o.drew);
                    if (g.rd_val != o.rd_val) report("read_value", g.rd_val, o.rd_val);
                end
                if (m_axis_tdata[23:22] != 2'b00) report("tdata padding", m_axis_tdata[23:22], 0);
            end
            err_count <= errs;
            pending <= outcome_q.size();
            model_pc <= pc;
        end
    end

endmodule

// ===== dv/chip8_instruction_executor_tb.sv =====
module chip8_instruction_executor_tb;
    import c8x_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 10_000_000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    int          err_count;
    int          pending;
    logic [11:0] model_pc;
    bit          gaps_on;
    int          sent;
    longint      cycles;

    chip8_instruction_executor u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    chip8_instruction_executor_checker u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .err_count     (err_count),
        .pending       (pending),
        .model_pc      (model_pc)
    );

    initial clk = 0;
    always #10 clk = ~clk;

    // watchdog
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side back-pressure in bursts
    initial
    begin
        m_axis_tready = 0;
        @(posedge rst_n);
        forever
        begin
            if (gaps_on && $urandom_range(0, 2) == 0)
            begin
                m_axis_tready <= 0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            m_axis_tready <= 1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    // one command transaction, with an optional idle burst ahead of it
    task automatic send_cmd(input logic [1:0] cmd, input logic [11:0] addr,
                            input logic [7:0] dat, input logic [7:0] kc, input logic [7:0] rb);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {2'b00, rb, kc, dat, addr, cmd};
        do @(posedge clk); while (!s_axis_tready);
        sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic logic [7:0] pick_key();
        string hexs;
        hexs = "0123456789abcdefABCDEF";
        if ($urandom_range(0, 1)) return hexs[$urandom_range(0, 21)];
        return $urandom_range(0, 255);
    endfunction

    // random instruction, mostly well-formed, jumps mostly kept inside the window
    function automatic logic [15:0] make_op(input logic [11:0] base, input int len);
        logic [3:0]  kind, x, y, n;
        logic [7:0]  nn;
        logic [11:0] tgt;
        logic [3:0]  alu_ops [9];
        logic [7:0]  misc_ops [9];
        alu_ops = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR,
                    ALU_SBN, ALU_SHL};
        misc_ops = '{MX_GDT, MX_KEY, MX_SDT, MX_SST, MX_ADDI, MX_FONT, MX_BCD,
                     MX_STR, MX_LDR};
        kind = $urandom_range(0, 15);
        x = $urandom_range(0, 15);
        y = $urandom_range(0, 15);
        n = $urandom_range(0, 15);
        nn = $urandom_range(0, 255);
        tgt = base + 12'(2 * $urandom_range(0, len - 1));
        if ($urandom_range(0, 7) == 0) tgt = $urandom_range(0, 4095);
        case (kind)
            K_SYS:
            begin
                case ($urandom_range(0, 9))
                    0:       return OP_CLS;
                    1, 2, 3: return $urandom_range(0, 4095);
                    default: return OP_RET;
                endcase
            end
            K_JP, K_CALL, K_JPV0: return {kind, tgt};
            K_ALU:
            begin
                if ($urandom_range(0, 7) != 0) n = alu_ops[$urandom_range(0, 8)];
                return {kind, x, y, n};
            end
            K_DRW:
            begin
                if ($urandom_range(0, 5) != 0) n = $urandom_range(0, 5);
                return {kind, x, y, n};
            end
            K_KEY:
            begin
                if ($urandom_range(0, 7) != 0) nn = $urandom_range(0, 1) ? KEY_SKP : KEY_SKNP;
                return {kind, x, nn};
            end
            K_MISC:
            begin
                if ($urandom_range(0, 7) != 0) nn = misc_ops[$urandom_range(0, 8)];
                return {kind, x, nn};
            end
            default: return {kind, x, y, n};
        endcase
    endfunction

    // stray commands anywhere in memory and on the screen
    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send_cmd(CMD_LOAD, $urandom_range(0, 4095), $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom_range(0, 255));
            1: send_cmd(CMD_RD_PIX, $urandom_range(0, 1) ? $urandom_range(0, 4095)
                        : $urandom_range(0, 511), $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom_range(0, 255));
            2: send_cmd(CMD_RD_MEM, $urandom_range(0, 4095), $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom_range(0, 255));
            default: send_cmd(CMD_EXEC, $urandom_range(0, 4095), $urandom_range(0, 255),
                              pick_key(), $urandom_range(0, 255));
        endcase
    endtask

    // jump to a fresh window, fill it with a program and step through it
    task automatic run_program();
        logic [11:0] base, p;
        logic [15:0] op;
        int len;
        len = $urandom_range(2, 10);
        base = 12'(2 * $urandom_range(40, 2030));
        wait_drained();
        p = model_pc;
        send_cmd(CMD_LOAD, p, {4'(K_JP), base[11:8]}, 0, 0);
        send_cmd(CMD_LOAD, p + 12'd1, base[7:0], 0, 0);
        send_cmd(CMD_EXEC, 0, 0, pick_key(), $urandom_range(0, 255));
        for (int i = 0; i < len; i++)
        begin
            op = make_op(base, len);
            send_cmd(CMD_LOAD, base + 12'(2 * i), op[15:8], 0, 0);
            send_cmd(CMD_LOAD, base + 12'(2 * i + 1), op[7:0], 0, 0);
        end
        for (int i = 0; i < len + $urandom_range(0, 6); i++)
        begin
            if ($urandom_range(0, 6) == 0) send_noise();
            send_cmd(CMD_EXEC, $urandom_range(0, 4095), $urandom_range(0, 255),
                     pick_key(), $urandom_range(0, 255));
        end
    endtask

    initial
    begin
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        gaps_on = 1;
        sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;

        // reads and a load at the corners of memory and screen
        send_cmd(CMD_RD_MEM, 12'd0, 8'hFF, 8'hFF, 8'hFF);
        send_cmd(CMD_RD_MEM, 12'd79, 0, 0, 0);
        send_cmd(CMD_RD_PIX, 12'hFFF, 0, 0, 0);
        send_cmd(CMD_RD_PIX, 12'd0, 0, 0, 0);
        send_cmd(CMD_LOAD, 12'hFFF, 8'hFF, 0, 0);
        send_cmd(CMD_RD_MEM, 12'hFFF, 0, 0, 0);

        // a call to itself sixteen times writes every stack entry and wraps the pointer
        send_cmd(CMD_LOAD, PC_RESET, {4'(K_CALL), PC_RESET[11:8]}, 0, 0);
        send_cmd(CMD_LOAD, PC_RESET + 12'd1, PC_RESET[7:0], 0, 0);
        repeat (16) send_cmd(CMD_EXEC, 0, 0, 0, 0);

        // pc wraps past the top of memory into the glyph bytes
        send_cmd(CMD_LOAD, PC_RESET, {4'(K_JP), 4'hF}, 0, 0);
        send_cmd(CMD_LOAD, PC_RESET + 12'd1, 8'hFE, 0, 0);
        send_cmd(CMD_LOAD, 12'hFFE, {4'(K_LDI8), 4'h0}, 0, 0);
        repeat (3) send_cmd(CMD_EXEC, 0, 0, 8'h41, 8'hFF);

        // random programs with stray commands in between
        while (sent < 1000)
        begin
            if (sent > 850) gaps_on = 0;
            if ($urandom_range(0, 4) == 0) send_noise();
            else run_program();
        end

        wait_drained();
        repeat (50) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
